@@ rtl/wsd_pkg.sv @@
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and codes shared by the WebSocket frame deframer modules.
// ----------------------------------------------------------------------------
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR1    = 3'd0,
    PH_HDR2    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  // result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_FRAG_CTRL  = 3'd1;
  localparam logic [2:0] ERR_RSV_BIT    = 3'd2;
  localparam logic [2:0] ERR_BAD_OPCODE = 3'd3;
  localparam logic [2:0] ERR_UNMASKED   = 3'd4;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // one classified beat, passed from front to back
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [2:0]  ecode;
    logic [3:0]  opcode;
    logic        fin;
    logic [63:0] length;
    logic        fend;
    logic        key_load;
    logic [1:0]  key_index;
  } entry_t;

endpackage

@@ rtl/wsd_front.sv @@
// ----------------------------------------------------------------------------
// wsd_front
// Frame phase tracking: classifies each incoming byte and builds a queue entry.
// ----------------------------------------------------------------------------
module wsd_front
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] in_byte,
  output entry_t     entry
);

  phase_t      phase, phase_next;
  logic [3:0]  held_opcode, held_opcode_next;
  logic        held_fin, held_fin_next;
  logic [2:0]  held_rsv, held_rsv_next;
  logic [63:0] length_value, length_value_next;
  logic [3:0]  length_bytes_left, length_bytes_left_next;
  logic [2:0]  key_bytes_left, key_bytes_left_next;
  logic [63:0] payload_left, payload_left_next;
  logic [1:0]  key_index, key_index_next;

  logic [6:0]  len7;
  logic [2:0]  hdr_err;
  logic        ext_last, key_last, pay_last;

  assign len7     = in_byte[6:0];
  assign ext_last = (length_bytes_left <= 4'd1);
  assign key_last = (key_bytes_left <= 3'd1);
  assign pay_last = (payload_left <= 64'd1);

  // header checks, first failing one wins
  always_comb begin
    if (!held_fin && held_opcode > 4'h7) begin
      hdr_err = ERR_FRAG_CTRL;
    end else if (held_rsv != 3'd0) begin
      hdr_err = ERR_RSV_BIT;
    end else if ((held_opcode >= 4'h3 && held_opcode <= 4'h7) || held_opcode >= 4'hB) begin
      hdr_err = ERR_BAD_OPCODE;
    end else if (!in_byte[7]) begin
      hdr_err = ERR_UNMASKED;
    end else begin
      hdr_err = ERR_NONE;
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HDR2: begin
        if (hdr_err != ERR_NONE) begin
          phase_next = PH_HDR1;
        end else if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
          phase_next = PH_EXTLEN;
        end else begin
          phase_next = PH_KEY;
        end
      end
      PH_EXTLEN: begin
        if (ext_last) phase_next = PH_KEY;
      end
      PH_KEY: begin
        if (key_last) phase_next = (length_value == 64'd0) ? PH_HDR1 : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (pay_last) phase_next = PH_HDR1;
      end
      default: phase_next = PH_HDR2;
    endcase
  end

  // datapath and entry
  always_comb begin
    held_opcode_next       = held_opcode;
    held_fin_next          = held_fin;
    held_rsv_next          = held_rsv;
    length_value_next      = length_value;
    length_bytes_left_next = length_bytes_left;
    key_bytes_left_next    = key_bytes_left;
    payload_left_next      = payload_left;
    key_index_next         = key_index;
    entry.kind      = KIND_HEADER;
    entry.data      = in_byte;
    entry.ecode     = ERR_NONE;
    entry.fend      = 1'b0;
    entry.key_load  = 1'b0;
    entry.key_index = key_index;
    unique case (phase)
      PH_HDR2: begin
        if (hdr_err != ERR_NONE) begin
          entry.kind        = KIND_ERROR;
          entry.ecode       = hdr_err;
          entry.fend        = 1'b1;
          length_value_next = 64'd0;
        end else if (len7 == LEN_EXT16) begin
          length_value_next      = 64'd0;
          length_bytes_left_next = 4'd2;
        end else if (len7 == LEN_EXT64) begin
          length_value_next      = 64'd0;
          length_bytes_left_next = 4'd8;
        end else begin
          length_value_next   = {57'd0, len7};
          key_bytes_left_next = 3'd4;
        end
      end
      PH_EXTLEN: begin
        length_value_next = {length_value[55:0], in_byte};
        if (ext_last) begin
          length_bytes_left_next = 4'd0;
          key_bytes_left_next    = 3'd4;
        end else begin
          length_bytes_left_next = length_bytes_left - 4'd1;
        end
      end
      PH_KEY: begin
        entry.key_load = 1'b1;
        if (key_last) begin
          key_bytes_left_next = 3'd0;
          payload_left_next   = length_value;
          key_index_next      = 2'd0;
          entry.fend          = (length_value == 64'd0);
        end else begin
          key_bytes_left_next = key_bytes_left - 3'd1;
        end
      end
      PH_PAYLOAD: begin
        entry.kind     = KIND_PAYLOAD;
        key_index_next = key_index + 2'd1;
        if (pay_last) begin
          payload_left_next = 64'd0;
          entry.fend        = 1'b1;
        end else begin
          payload_left_next = payload_left - 64'd1;
        end
      end
      default: begin
        held_fin_next          = in_byte[7];
        held_rsv_next          = in_byte[6:4];
        held_opcode_next       = in_byte[3:0];
        length_value_next      = 64'd0;
        length_bytes_left_next = 4'd0;
        key_bytes_left_next    = 3'd0;
        payload_left_next      = 64'd0;
        key_index_next         = 2'd0;
      end
    endcase
    entry.opcode = held_opcode_next;
    entry.fin    = held_fin_next;
    entry.length = length_value_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HDR1;
      held_opcode       <= 4'd0;
      held_fin          <= 1'b0;
      held_rsv          <= 3'd0;
      length_value      <= 64'd0;
      length_bytes_left <= 4'd0;
      key_bytes_left    <= 3'd0;
      payload_left      <= 64'd0;
      key_index         <= 2'd0;
    end else if (push) begin
      phase             <= phase_next;
      held_opcode       <= held_opcode_next;
      held_fin          <= held_fin_next;
      held_rsv          <= held_rsv_next;
      length_value      <= length_value_next;
      length_bytes_left <= length_bytes_left_next;
      key_bytes_left    <= key_bytes_left_next;
      payload_left      <= payload_left_next;
      key_index         <= key_index_next;
    end
  end

endmodule

@@ rtl/wsd_queue.sv @@
// ----------------------------------------------------------------------------
// wsd_queue
// Short FIFO of classified beats between front and back.
// ----------------------------------------------------------------------------
module wsd_queue
  import wsd_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wr_entry,
  input  logic   pop,
  output entry_t rd_entry,
  output logic   full,
  output logic   not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule

@@ rtl/wsd_back.sv @@
// ----------------------------------------------------------------------------
// wsd_back
// Holds the mask key, unmasks payload beats and drives the result register.
// ----------------------------------------------------------------------------
module wsd_back
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  entry_t      q_entry,
  output logic        pop,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  kind,
  output logic [7:0]  payload_byte,
  output logic [2:0]  error_code,
  output logic [3:0]  frame_opcode,
  output logic        final_fragment,
  output logic [63:0] payload_length,
  output logic        frame_end
);

  logic [31:0] mask_key;
  logic [7:0]  key_byte;

  assign pop = q_valid && (!result_valid || result_ready);

  // key byte 0 is the first one received, held in the top byte
  always_comb begin
    case (q_entry.key_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop && q_entry.key_load) mask_key <= {mask_key[23:0], q_entry.data};
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind           <= q_entry.kind;
      payload_byte   <= (q_entry.kind == KIND_PAYLOAD) ? (q_entry.data ^ key_byte) : 8'd0;
      error_code     <= q_entry.ecode;
      frame_opcode   <= q_entry.opcode;
      final_fragment <= q_entry.fin;
      payload_length <= q_entry.length;
      frame_end      <= q_entry.fend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/websocket_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Client-to-server WebSocket frame parser: header decode, checks, unmasking.
// ----------------------------------------------------------------------------
//  channel   handshake                   payload
//  -------   -------------------------   ---------------------------------
//  input     byte_valid / byte_ready     in_byte
//  output    result_valid / result_ready kind, payload_byte, error_code,
//                                        frame_opcode, final_fragment,
//                                        payload_length, frame_end
//
//  One byte per cycle sustained while the output is not stalled; one result
//  per byte. The front classifies each taken byte into the queue; the back
//  pops it from there and registers the result.
//  rst clears the frame phase, the queue and the result valid.
//  A stalled output is absorbed by the QUEUE_DEPTH-entry queue; byte_ready
//  drops only once it is full.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
  import wsd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  in_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  kind,
  output logic [7:0]  payload_byte,
  output logic [2:0]  error_code,
  output logic [3:0]  frame_opcode,
  output logic        final_fragment,
  output logic [63:0] payload_length,
  output logic        frame_end
);

  entry_t front_entry, back_entry;
  logic   push, pop, q_full, q_valid;

  assign byte_ready = !q_full;
  assign push       = byte_valid && byte_ready;

  wsd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .in_byte (in_byte),
    .entry   (front_entry)
  );

  wsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_entry  (front_entry),
    .pop       (pop),
    .rd_entry  (back_entry),
    .full      (q_full),
    .not_empty (q_valid)
  );

  wsd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_entry        (back_entry),
    .pop            (pop),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .kind           (kind),
    .payload_byte   (payload_byte),
    .error_code     (error_code),
    .frame_opcode   (frame_opcode),
    .final_fragment (final_fragment),
    .payload_length (payload_length),
    .frame_end      (frame_end)
  );

endmodule
